// ===== rtl/core/rnp_pkg.sv =====
// ----------------------------------------------------------------------------
// Ringtone note parser package
// Shared types, character codes, register indexes and the note period table.
// ----------------------------------------------------------------------------
package rnp_pkg;

	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [15:0] REST_PERIOD = 16'd10000;
	localparam logic [20:0] COUNT_MAX   = 21'h1F_FFFF;
	localparam logic [32:0] PLAIN_NUM   = 33'd3600000000;
	localparam logic [32:0] DOTTED_NUM  = 33'd5400000000;
	localparam int unsigned DIV_STEPS   = 33;

	// Reset values of the configuration registers and of the token octave.
	localparam logic [2:0] OCTAVE_RST = 3'd5;
	localparam logic [5:0] LENGTH_RST = 6'd4;
	localparam logic [9:0] TEMPO_RST  = 10'd125;

	// Configuration register indexes.
	localparam logic [1:0] CFG_IDX_OCTAVE = 2'd0;
	localparam logic [1:0] CFG_IDX_LENGTH = 2'd1;
	localparam logic [1:0] CFG_IDX_TEMPO  = 2'd2;

	// Character codes.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_END   = 8'h53;
	localparam logic [7:0] LT_A     = 8'h61;
	localparam logic [7:0] LT_B     = 8'h62;
	localparam logic [7:0] LT_C     = 8'h63;
	localparam logic [7:0] LT_D     = 8'h64;
	localparam logic [7:0] LT_E     = 8'h65;
	localparam logic [7:0] LT_F     = 8'h66;
	localparam logic [7:0] LT_G     = 8'h67;
	localparam logic [7:0] LT_P     = 8'h70;

	typedef enum logic [2:0] {
		PH_START,
		PH_ONE,
		PH_THREE,
		PH_LETTER,
		PH_SHARP,
		PH_DOT1,
		PH_OCT,
		PH_TAIL
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL1,
		BK_MUL2,
		BK_DIV,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic [2:0] default_octave;
		logic [5:0] default_length;
		logic [9:0] tempo_bpm;
	} cfg_t;

	// One note handed from the parser to the duration unit.
	typedef struct packed {
		logic [15:0] period;
		logic        tone_on;
		logic [5:0]  length;
		logic [9:0]  bpm;
		logic        dotted;
		logic        eom;
		logic        empty;
	} job_t;

	// Base period of a letter; an unknown letter keeps the held period.
	function automatic logic [15:0] note_period(input logic sharp, input logic [7:0] letter,
		input logic [15:0] held);
		logic [15:0] p;
		p = held;
		if (sharp) begin
			case (letter)
				LT_A: p = 16'd53629;
				LT_C: p = 16'd45097;
				LT_D: p = 16'd40176;
				LT_F: p = 16'd33784;
				LT_G: p = 16'd30098;
				default: p = held;
			endcase
		end else begin
			case (letter)
				LT_A: p = 16'd56818;
				LT_B: p = 16'd50620;
				LT_C: p = 16'd47778;
				LT_D: p = 16'd42565;
				LT_E: p = 16'd37921;
				LT_F: p = 16'd35793;
				LT_G: p = 16'd31888;
				LT_P: p = 16'd0;
				default: p = held;
			endcase
		end
		return p;
	endfunction

endpackage

// ===== rtl/core/ringtone_note_parser_core.sv =====
// A closing ',' or 'S' queues a note; the duration unit pops it, runs BK_MUL1, BK_MUL2
// and BK_DIV, or goes straight to BK_DONE for an end with no note pending, and then
// loads the output register once it is free. One melody byte is taken per cycle while
// the note queue has room; the duration unit works on one note at a time with its
// one-bit-per-cycle divider. Asynchronous active-low reset clears the parser, the queue
// and the output; configuration returns to octave 5, length 4 and 125 bpm.
// ----------------------------------------------------------------------------
// Ringtone note parser core
// Parses ringtone note text into tone periods and note durations.
// ----------------------------------------------------------------------------
module ringtone_note_parser_core #(
	parameter int unsigned QUEUE_DEPTH = rnp_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	// Melody byte channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  melody_byte,
	// Note result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] tone_period,
	output logic        tone_on,
	output logic [20:0] period_count,
	output logic        end_of_melody
);

	// The configuration registers live here and are shared by the parser. The
	// default octave is used when a letter arrives; length and tempo are copied
	// into the queued note at the delimiter, so the duration unit never looks
	// back at them.
	rnp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_octave <= rnp_pkg::OCTAVE_RST;
			cfg_q.default_length <= rnp_pkg::LENGTH_RST;
			cfg_q.tempo_bpm      <= rnp_pkg::TEMPO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rnp_pkg::CFG_IDX_OCTAVE: cfg_q.default_octave <= cfg_data[2:0];
				rnp_pkg::CFG_IDX_LENGTH: cfg_q.default_length <= cfg_data[5:0];
				rnp_pkg::CFG_IDX_TEMPO:  cfg_q.tempo_bpm      <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// The front end takes one byte per transfer. It stalls only when the note
	// queue is full, so a burst of notes is absorbed while the divider works.
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	rnp_pkg::job_t push_job;
	rnp_pkg::job_t pop_job;

	rnp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.melody_byte (melody_byte),
		.cfg         (cfg_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	rnp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_job   (pop_job)
	);

	// The back end forms the divisor with two registered multiplies, runs the
	// restoring division and parks the result in the output register, from
	// which it leaves by an ordinary transfer.
	rnp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_job         (pop_job),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.tone_period   (tone_period),
		.tone_on       (tone_on),
		.period_count  (period_count),
		.end_of_melody (end_of_melody)
	);

`ifndef NO_ASSERTIONS
	// The parser never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> !q_push)
		else $error("note pushed into a full queue");

	// A silent result is either a rest or the end of an empty melody.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !tone_on) |->
		(tone_period == rnp_pkg::REST_PERIOD || tone_period == 16'd0))
		else $error("silent result with a tone period");

	// A zero period only comes from an empty end, which lasts no time.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tone_period == 16'd0) |-> (end_of_melody && period_count == 21'd0))
		else $error("zero period outside an empty end");
`endif

endmodule

// ===== rtl/core/rnp_front.sv =====
// ----------------------------------------------------------------------------
// Ringtone note parser front end
// Takes melody bytes, tracks the token fields and queues one note per token.
// ----------------------------------------------------------------------------
module rnp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     melody_byte,
	input  rnp_pkg::cfg_t  cfg,
	input  logic           q_full,
	output logic           q_push,
	output rnp_pkg::job_t  q_job
);

	rnp_pkg::phase_t phase_q, ph;
	logic [5:0]  len_q, len;
	logic [7:0]  letter_q, letter;
	logic [2:0]  oct_q, oct;
	logic        dot_q, dot;
	logic        sharp_q, sharp;
	logic        pend_q, pend;
	logic [15:0] held_q;
	logic [15:0] base;
	logic [1:0]  shift;
	logic        done;
	logic        accept;
	logic        is_space, is_comma, is_end;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign is_space = (melody_byte == rnp_pkg::CH_SPACE);
	assign is_comma = (melody_byte == rnp_pkg::CH_COMMA);
	assign is_end   = (melody_byte == rnp_pkg::CH_END);

	// Walk the token phases; a byte that does not fit a slot falls to the next.
	always_comb begin
		ph     = phase_q;
		len    = len_q;
		letter = letter_q;
		oct    = oct_q;
		dot    = dot_q;
		sharp  = sharp_q;
		pend   = pend_q;
		done   = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!done) begin
				case (ph)
					rnp_pkg::PH_START: begin
						if (melody_byte == rnp_pkg::CH_EIGHT || melody_byte == rnp_pkg::CH_FOUR
							|| melody_byte == rnp_pkg::CH_TWO) begin
							len  = {2'b00, melody_byte[3:0]};
							ph   = rnp_pkg::PH_LETTER;
							done = 1'b1;
						end else if (melody_byte == rnp_pkg::CH_ONE) begin
							len  = 6'd1;
							ph   = rnp_pkg::PH_ONE;
							done = 1'b1;
						end else if (melody_byte == rnp_pkg::CH_THREE) begin
							ph   = rnp_pkg::PH_THREE;
							done = 1'b1;
						end else begin
							ph = rnp_pkg::PH_LETTER;
						end
					end
					rnp_pkg::PH_ONE: begin
						ph = rnp_pkg::PH_LETTER;
						if (melody_byte == rnp_pkg::CH_SIX) begin
							len  = 6'd16;
							done = 1'b1;
						end
					end
					rnp_pkg::PH_THREE: begin
						if (melody_byte == rnp_pkg::CH_TWO) begin
							len  = 6'd32;
							ph   = rnp_pkg::PH_LETTER;
							done = 1'b1;
						end else begin
							letter = rnp_pkg::CH_THREE;
							pend   = 1'b1;
							oct    = cfg.default_octave;
							ph     = rnp_pkg::PH_SHARP;
						end
					end
					rnp_pkg::PH_LETTER: begin
						letter = melody_byte;
						pend   = 1'b1;
						oct    = cfg.default_octave;
						ph     = rnp_pkg::PH_SHARP;
						done   = 1'b1;
					end
					rnp_pkg::PH_SHARP: begin
						ph = rnp_pkg::PH_DOT1;
						if (melody_byte == rnp_pkg::CH_HASH) begin
							sharp = 1'b1;
							done  = 1'b1;
						end
					end
					rnp_pkg::PH_DOT1: begin
						ph = rnp_pkg::PH_OCT;
						if (melody_byte == rnp_pkg::CH_DOT) begin
							dot  = 1'b1;
							done = 1'b1;
						end
					end
					rnp_pkg::PH_OCT: begin
						ph = rnp_pkg::PH_TAIL;
						if (melody_byte >= rnp_pkg::CH_FOUR && melody_byte <= rnp_pkg::CH_SEVEN) begin
							oct  = melody_byte[2:0];
							done = 1'b1;
						end
					end
					default: begin
						if (melody_byte == rnp_pkg::CH_DOT) begin
							dot = 1'b1;
						end
						done = 1'b1;
					end
				endcase
			end
		end
	end

	// Note resolution at the closing delimiter.
	always_comb begin
		base = rnp_pkg::note_period(sharp_q, letter_q, held_q);
		case (oct_q)
			3'd5:    shift = 2'd1;
			3'd6:    shift = 2'd2;
			3'd7:    shift = 2'd3;
			default: shift = 2'd0;
		endcase
		q_job.length = (len_q != 6'd0) ? len_q : cfg.default_length;
		q_job.bpm    = cfg.tempo_bpm;
		q_job.dotted = dot_q;
		q_job.eom    = is_end;
		q_job.empty  = !pend_q;
		if (!pend_q) begin
			q_job.period  = 16'd0;
			q_job.tone_on = 1'b0;
		end else if (base == 16'd0) begin
			q_job.period  = rnp_pkg::REST_PERIOD;
			q_job.tone_on = 1'b0;
		end else begin
			q_job.period  = base >> shift;
			q_job.tone_on = 1'b1;
		end
	end

	assign q_push = accept && ((is_comma && pend_q) || is_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rnp_pkg::PH_START;
			len_q    <= 6'd0;
			letter_q <= 8'd0;
			oct_q    <= rnp_pkg::OCTAVE_RST;
			dot_q    <= 1'b0;
			sharp_q  <= 1'b0;
			pend_q   <= 1'b0;
			held_q   <= 16'd0;
		end else if (accept && !is_space) begin
			if (is_comma || is_end) begin
				if (pend_q) begin
					held_q <= base;
				end
				phase_q  <= rnp_pkg::PH_START;
				len_q    <= 6'd0;
				letter_q <= 8'd0;
				dot_q    <= 1'b0;
				sharp_q  <= 1'b0;
				pend_q   <= 1'b0;
			end else begin
				phase_q  <= ph;
				len_q    <= len;
				letter_q <= letter;
				oct_q    <= oct;
				dot_q    <= dot;
				sharp_q  <= sharp;
				pend_q   <= pend;
			end
		end
	end

endmodule

// ===== rtl/core/rnp_queue.sv =====
// ----------------------------------------------------------------------------
// Ringtone note parser note queue
// Small first-in first-out store between the parser and the duration unit.
// ----------------------------------------------------------------------------
module rnp_queue #(
	parameter int unsigned DEPTH = rnp_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rnp_pkg::job_t  push_job,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output rnp_pkg::job_t  pop_job
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rnp_pkg::job_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job   = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/rnp_back.sv =====
// ----------------------------------------------------------------------------
// Ringtone note parser duration unit
// Forms period x tempo x length, divides it into the note time bit by bit and
// holds the finished result for the output transfer.
// ----------------------------------------------------------------------------
module rnp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  rnp_pkg::job_t  q_job,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [15:0]    tone_period,
	output logic           tone_on,
	output logic [20:0]    period_count,
	output logic           end_of_melody
);

	localparam int unsigned STEP_W = $clog2(rnp_pkg::DIV_STEPS + 1);

	rnp_pkg::back_state_t state_q, state_nxt;
	rnp_pkg::job_t job_q;
	logic [25:0]       prod_q;
	logic [31:0]       den_q;
	logic [31:0]       rem_q;
	logic [32:0]       num_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [15:0]       period_q;
	logic              on_q;
	logic [20:0]       count_q;
	logic              eom_q;
	logic              load_out;
	logic              last_step;
	logic [32:0]       trial;
	logic [32:0]       diff;
	logic              ge;
	logic [20:0]       count_res;

	assign last_step = (step_q == STEP_W'(1));
	assign trial     = {rem_q, num_q[32]};
	assign diff      = trial - {1'b0, den_q};
	assign ge        = (trial >= {1'b0, den_q});

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rnp_pkg::BK_IDLE: begin
				if (q_valid) begin
					state_nxt = q_job.empty ? rnp_pkg::BK_DONE : rnp_pkg::BK_MUL1;
				end
			end
			rnp_pkg::BK_MUL1: state_nxt = rnp_pkg::BK_MUL2;
			rnp_pkg::BK_MUL2: state_nxt = rnp_pkg::BK_DIV;
			rnp_pkg::BK_DIV: begin
				if (last_step) begin
					state_nxt = rnp_pkg::BK_DONE;
				end
			end
			rnp_pkg::BK_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = rnp_pkg::BK_IDLE;
				end
			end
			default: state_nxt = rnp_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			rnp_pkg::BK_IDLE: q_pop = q_valid;
			rnp_pkg::BK_DONE: load_out = !out_valid_q || !out_stall;
			default: begin
				q_pop    = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	// A zero divisor or an oversized quotient saturates.
	always_comb begin
		if (job_q.empty) begin
			count_res = 21'd0;
		end else if (den_q == 32'd0 || num_q > {12'd0, rnp_pkg::COUNT_MAX}) begin
			count_res = rnp_pkg::COUNT_MAX;
		end else begin
			count_res = num_q[20:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rnp_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rnp_pkg::BK_IDLE: begin
				if (q_pop) begin
					job_q <= q_job;
				end
			end
			rnp_pkg::BK_MUL1: prod_q <= 26'(job_q.period) * 26'(job_q.bpm);
			rnp_pkg::BK_MUL2: begin
				den_q  <= 32'(prod_q) * 32'(job_q.length);
				num_q  <= job_q.dotted ? rnp_pkg::DOTTED_NUM : rnp_pkg::PLAIN_NUM;
				rem_q  <= 32'd0;
				step_q <= STEP_W'(rnp_pkg::DIV_STEPS);
			end
			rnp_pkg::BK_DIV: begin
				rem_q  <= ge ? diff[31:0] : trial[31:0];
				num_q  <= {num_q[31:0], ge};
				step_q <= step_q - 1'b1;
			end
			default: begin
				if (load_out) begin
					period_q <= job_q.period;
					on_q     <= job_q.tone_on;
					count_q  <= count_res;
					eom_q    <= job_q.eom;
				end
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign tone_period   = period_q;
	assign tone_on       = on_q;
	assign period_count  = count_q;
	assign end_of_melody = eom_q;

endmodule
